/* design/rc_quad_frame_builder_top_macros.svh */
// Assertion macros shared by the frame builder modules.
// The clock is clock and the reset is reset in every module that uses them.
`ifndef RC_QUAD_FRAME_BUILDER_TOP_MACROS_SVH
`define RC_QUAD_FRAME_BUILDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RCQ_ASSERT_IMP(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);
`define RCQ_ASSERT_NXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);
`else
`define RCQ_ASSERT_IMP(label, cond, expr, msg)
`define RCQ_ASSERT_NXT(label, cond, expr, msg)
`endif
`endif

/* design/rcq_pkg.sv */
`timescale 1ns / 1ps
package rcq_pkg;

   localparam int FULL_SCALE_DEFAULT = 10000;
   localparam int FRAME_BYTES = 16;
   localparam int BYTE_INDEX_W = $clog2(FRAME_BYTES);
   localparam int HOP_SLOTS = 4;
   localparam int HOP_SLOT_W = $clog2(HOP_SLOTS);
   localparam int HOP_POS_W = $clog2(2 * HOP_SLOTS);
   localparam int ID_ROWS = 8;
   localparam int ID_SELECT_W = $clog2(ID_ROWS);

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROTOCOL_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_SELECT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIND_LENGTH = 2'd2;

   localparam logic [CSR_DATA_W-1:0] BIND_LENGTH_RESET = 16'd150;

   localparam logic [7:0] TRIM_NEUTRAL = 8'h40;
   localparam logic [7:0] BIND_FLAGS = 8'hC0;
   localparam logic [7:0] DATA_FLAGS_BASE = 8'h04;
   localparam logic [7:0] ALT_RATE_BIT = 8'h20;
   localparam logic [7:0] ALT_FLAG_MASK = ~8'h24;
   localparam logic [7:0] SIGN_BIT = 8'h80;
   localparam logic [7:0] MAG_MAX = 8'h7F;
   localparam logic [7:0] BYTE_MAX = 8'hFF;

   localparam logic [7:0] ID_BYTE_FIRST [ID_ROWS] = '{
      8'h4F, 8'h90, 8'h24, 8'h7A, 8'h61, 8'h5D, 8'hFD, 8'h86
   };
   localparam logic [7:0] ID_BYTE_SECOND [ID_ROWS] = '{
      8'h1C, 8'h1C, 8'h36, 8'h40, 8'h31, 8'h37, 8'h4F, 8'h3C
   };
   localparam logic [7:0] ID_HOPS [ID_ROWS][HOP_SLOTS] = '{
      '{8'h3A, 8'h35, 8'h4A, 8'h45}, '{8'h2E, 8'h36, 8'h3E, 8'h46},
      '{8'h32, 8'h3E, 8'h42, 8'h4E}, '{8'h2E, 8'h3C, 8'h3E, 8'h4C},
      '{8'h2F, 8'h3B, 8'h3F, 8'h4B}, '{8'h33, 8'h3B, 8'h43, 8'h4B},
      '{8'h33, 8'h3B, 8'h43, 8'h4B}, '{8'h34, 8'h3E, 8'h44, 8'h4E}
   };
   localparam logic [7:0] BIND_HOPS [HOP_SLOTS] = '{8'h36, 8'h3E, 8'h46, 8'h2E};

   typedef struct packed {
      logic headless_on;
      logic return_home_on;
      logic flip_on;
      logic photo_on;
      logic video_on;
      logic led_negative;
      logic arm_positive;
   } rcq_flags_type;

   typedef struct packed {
      logic signed [15:0] throttle;
      logic signed [15:0] rudder;
      logic signed [15:0] elevator;
      logic signed [15:0] aileron;
      rcq_flags_type flags;
   } rcq_item_type;

   typedef struct packed {
      rcq_item_type item;
      logic bind_frame;
      logic [7:0] radio_channel;
   } rcq_tick_type;

   typedef struct packed {
      logic [7:0] throttle_byte;
      logic [7:0] rudder_byte;
      logic [7:0] elevator_byte;
      logic [7:0] aileron_byte;
      rcq_flags_type flags;
      logic bind_frame;
      logic [7:0] radio_channel;
   } rcq_stage_type;

   typedef struct packed {
      logic protocol_format;
      logic [ID_SELECT_W-1:0] id_select;
   } rcq_cfg_type;

   typedef logic [FRAME_BYTES-1:0][7:0] rcq_frame_type;

   function automatic logic [7:0] hop_channel(input logic bind_frame,
                                              input logic [ID_SELECT_W-1:0] row,
                                              input logic [HOP_SLOT_W-1:0] slot);
      logic [7:0] entry;
      logic [9:0] times3;
      entry = bind_frame ? BIND_HOPS[slot] : ID_HOPS[row][slot];
      times3 = {2'b00, entry} + {1'b0, entry, 1'b0};
      return times3[7:0];
   endfunction

endpackage

/* design/rc_quad_frame_builder_top.sv */
`timescale 1ns / 1ps
// Frame builder for a four-channel toy quadcopter link. Each req transfer is one frame tick
// and, except for the tick that ends the bind countdown, yields sixteen rsp transfers, one
// frame byte per cycle while rsp_tready holds, ending with the additive checksum on tlast;
// tuser marks bind frames. A tick passes a capture register, a scaling register (one
// reciprocal multiply per stick) and the frame buffer in that order, and the next tick is
// taken while the current frame streams out. Sustained throughput is set by the single
// byte-wide output port. The tick that ends the bind countdown produces no transfer.
// Writing bind_length restarts the bind phase; the user must write registers only while
// the block is idle, which the block itself does not enforce.
module rc_quad_frame_builder_top
   import rcq_pkg::*;
#(
   parameter int FULL_SCALE = FULL_SCALE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // throttle[15:0], rudder[31:16], elevator[47:32], aileron[63:48], headless_on[64],
   // return_home_on[65], flip_on[66], photo_on[67], video_on[68], led_negative[69],
   // arm_positive[70], zero[71]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // frame_byte[7:0], byte_index[11:8], radio_channel[19:12], zero[23:20]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // bind_frame[0]
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   rcq_item_type  req_item;
   rcq_cfg_type   cfg;
   logic          s1_valid, s1_ready;
   rcq_tick_type  s1_tick;
   logic          s2_valid, s2_ready;
   rcq_stage_type s2_stage;
   rcq_frame_type frame;

   logic [7:0]              frame_byte;
   logic [BYTE_INDEX_W-1:0] byte_index;
   logic [7:0]              channel;

   assign req_item.throttle = req_tdata[15:0];
   assign req_item.rudder = req_tdata[31:16];
   assign req_item.elevator = req_tdata[47:32];
   assign req_item.aileron = req_tdata[63:48];
   assign req_item.flags.headless_on = req_tdata[64];
   assign req_item.flags.return_home_on = req_tdata[65];
   assign req_item.flags.flip_on = req_tdata[66];
   assign req_item.flags.photo_on = req_tdata[67];
   assign req_item.flags.video_on = req_tdata[68];
   assign req_item.flags.led_negative = req_tdata[69];
   assign req_item.flags.arm_positive = req_tdata[70];

   rcq_tick_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .s1_valid   (s1_valid),
      .s1_ready   (s1_ready),
      .s1_tick    (s1_tick)
   );

   rcq_scale_stage #(
      .FULL_SCALE (FULL_SCALE)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_tick  (s1_tick),
      .s2_valid (s2_valid),
      .s2_ready (s2_ready),
      .s2_stage (s2_stage)
   );

   rcq_frame_asm u_asm (
      .stage (s2_stage),
      .cfg   (cfg),
      .frame (frame)
   );

   rcq_serializer u_ser (
      .clock         (clock),
      .reset         (reset),
      .s2_valid      (s2_valid),
      .s2_ready      (s2_ready),
      .frame         (frame),
      .radio_channel (s2_stage.radio_channel),
      .bind_frame    (s2_stage.bind_frame),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .frame_byte    (frame_byte),
      .byte_index    (byte_index),
      .channel       (channel),
      .bind_flag     (rsp_tuser),
      .last_byte     (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, channel, byte_index, frame_byte};

endmodule

/* design/rcq_tick_ctrl.sv */
`timescale 1ns / 1ps
`include "rc_quad_frame_builder_top_macros.svh"
module rcq_tick_ctrl
   import rcq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rcq_item_type           req_item,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output rcq_cfg_type            cfg,
   output logic                   s1_valid,
   input  logic                   s1_ready,
   output rcq_tick_type           s1_tick
);

   logic                   in_data_phase_ff, in_data_phase_in;
   logic [CSR_DATA_W-1:0]  bind_remaining_ff, bind_remaining_in;
   logic [HOP_POS_W-1:0]   hop_ff, hop_in;
   logic                   protocol_format_ff, protocol_format_in;
   logic [ID_SELECT_W-1:0] id_select_ff, id_select_in;
   logic                   s1_valid_ff, s1_valid_in;
   rcq_tick_type           s1_ff, s1_in;

   logic                   accept;
   logic                   skip;
   logic [HOP_POS_W-1:0]   hop_next;

   assign req_tready = !s1_valid_ff || s1_ready;
   assign accept = req_tvalid && req_tready;
   assign skip = !in_data_phase_ff && (bind_remaining_ff == '0);
   assign hop_next = (hop_ff == HOP_POS_W'(2 * HOP_SLOTS - 1)) ? '0 : hop_ff + 1'b1;

   always_comb begin
      in_data_phase_in = in_data_phase_ff;
      bind_remaining_in = bind_remaining_ff;
      hop_in = hop_ff;
      protocol_format_in = protocol_format_ff;
      id_select_in = id_select_ff;
      s1_valid_in = s1_valid_ff;
      s1_in = s1_ff;

      if (s1_ready) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         if (skip) begin
            in_data_phase_in = 1'b1;
         end else begin
            if (!in_data_phase_ff) begin
               bind_remaining_in = bind_remaining_ff - 1'b1;
            end
            hop_in = hop_next;
            s1_valid_in = 1'b1;
            s1_in.item = req_item;
            s1_in.bind_frame = !in_data_phase_ff;
            s1_in.radio_channel = hop_channel(!in_data_phase_ff, id_select_ff,
                                              hop_next[HOP_POS_W-1:1]);
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_PROTOCOL_FORMAT: begin
               protocol_format_in = csr_wdata[0];
            end
            CSR_ID_SELECT: begin
               id_select_in = csr_wdata[ID_SELECT_W-1:0];
            end
            CSR_BIND_LENGTH: begin
               bind_remaining_in = csr_wdata;
               in_data_phase_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_data_phase_ff <= 1'b0;
         bind_remaining_ff <= BIND_LENGTH_RESET;
         hop_ff <= '0;
         protocol_format_ff <= 1'b0;
         id_select_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_data_phase_ff <= in_data_phase_in;
         bind_remaining_ff <= bind_remaining_in;
         hop_ff <= hop_in;
         protocol_format_ff <= protocol_format_in;
         id_select_ff <= id_select_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign cfg.protocol_format = protocol_format_ff;
   assign cfg.id_select = id_select_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_tick = s1_ff;

   // The tick that ends the bind phase enters data phase without moving the hop position.
   `RCQ_ASSERT_NXT(a_bind_end_tick, accept && skip && !csr_we, in_data_phase_ff && $stable(hop_ff), "bind end tick did not enter data phase cleanly")
   // A tick that makes a frame is tagged by the phase it was accepted in.
   `RCQ_ASSERT_NXT(a_bind_tag, accept && !skip, s1_valid_ff && (s1_ff.bind_frame == !$past(in_data_phase_ff)), "frame tick carries the wrong bind tag")

endmodule

/* design/rcq_scale_stage.sv */
`timescale 1ns / 1ps
module rcq_scale_stage
   import rcq_pkg::*;
#(
   parameter int FULL_SCALE = FULL_SCALE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          s1_valid,
   output logic          s1_ready,
   input  rcq_tick_type  s1_tick,
   output logic          s2_valid,
   input  logic          s2_ready,
   output rcq_stage_type s2_stage
);

   // The quotient of mag * 127 by FULL_SCALE comes from a rounded-up reciprocal that is
   // exact for every product below 2**P_W.
   localparam int MAG_W = $clog2(FULL_SCALE + 1);
   localparam int P_W = $clog2(FULL_SCALE * 127 + 1);
   localparam int SHIFT = P_W + $clog2(FULL_SCALE);
   localparam int M_W = P_W + 1;
   localparam int PROD_W = P_W + M_W;
   localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(FULL_SCALE) - 64'd1) / FULL_SCALE;
   localparam logic signed [16:0] FS_POS = 17'(FULL_SCALE);
   localparam logic signed [16:0] FS_NEG = -FS_POS;

   function automatic logic [7:0] stick_byte(input logic signed [15:0] value);
      logic signed [16:0] wide;
      logic signed [16:0] lim;
      logic [16:0]        abs_val;
      logic               neg;
      logic [MAG_W-1:0]   mag;
      logic [P_W-1:0]     prod127;
      logic [PROD_W-1:0]  prod;
      wide = {value[15], value};
      if (wide > FS_POS) begin
         lim = FS_POS;
      end else if (wide < FS_NEG) begin
         lim = FS_NEG;
      end else begin
         lim = wide;
      end
      neg = lim[16];
      abs_val = neg ? 17'(-lim) : 17'(lim);
      mag = abs_val[MAG_W-1:0];
      prod127 = P_W'((MAG_W + 7)'({mag, 7'b0}) - (MAG_W + 7)'(mag));
      prod = PROD_W'(prod127) * PROD_W'(RECIP[M_W-1:0]);
      return {neg, prod[SHIFT+6:SHIFT]};
   endfunction

   logic          s2_valid_ff, s2_valid_in;
   rcq_stage_type s2_ff, s2_in;
   logic          load;

   assign s1_ready = !s2_valid_ff || s2_ready;
   assign load = s1_valid && s1_ready;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_in = s2_ff;
      if (s2_ready) begin
         s2_valid_in = 1'b0;
      end
      if (load) begin
         s2_valid_in = 1'b1;
         s2_in.throttle_byte = stick_byte(s1_tick.item.throttle);
         s2_in.rudder_byte = stick_byte(s1_tick.item.rudder);
         s2_in.elevator_byte = stick_byte(s1_tick.item.elevator);
         s2_in.aileron_byte = stick_byte(s1_tick.item.aileron);
         s2_in.flags = s1_tick.item.flags;
         s2_in.bind_frame = s1_tick.bind_frame;
         s2_in.radio_channel = s1_tick.radio_channel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2_stage = s2_ff;

endmodule

/* design/rcq_frame_asm.sv */
`timescale 1ns / 1ps
module rcq_frame_asm
   import rcq_pkg::*;
(
   input  rcq_stage_type stage,
   input  rcq_cfg_type   cfg,
   output rcq_frame_type frame
);

   function automatic logic [7:0] trim_of(input logic [7:0] x);
      logic [7:0] t;
      t = x[7] ? x : (MAG_MAX - x);
      return {1'b0, t[7:1]};
   endfunction

   logic [7:0] b [FRAME_BYTES];
   logic [7:0] lvl1 [8];
   logic [7:0] lvl2 [4];
   logic [7:0] lvl3 [2];
   logic [7:0] checksum;

   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         b[i] = '0;
      end
      b[0] = stage.throttle_byte[7] ? (BYTE_MAX - stage.throttle_byte)
                                    : (SIGN_BIT + stage.throttle_byte);
      b[1] = stage.rudder_byte;
      b[2] = SIGN_BIT ^ stage.elevator_byte;
      b[3] = stage.aileron_byte;
      b[4] = TRIM_NEUTRAL;
      b[5] = stage.flags.headless_on ? TRIM_NEUTRAL : trim_of(SIGN_BIT ^ stage.elevator_byte);
      b[6] = stage.flags.headless_on ? TRIM_NEUTRAL : trim_of(stage.aileron_byte);
      b[7] = ID_BYTE_FIRST[cfg.id_select];
      b[8] = ID_BYTE_SECOND[cfg.id_select];
      b[10] = {6'b0, stage.flags.return_home_on, stage.flags.headless_on};
      b[14] = BIND_FLAGS;
      if (!stage.bind_frame) begin
         b[14] = DATA_FLAGS_BASE | {2'b00, stage.flags.led_negative, stage.flags.video_on,
                                    stage.flags.photo_on, 2'b00, stage.flags.flip_on};
         if (cfg.protocol_format) begin
            b[10] = b[10] | ALT_RATE_BIT | {stage.flags.arm_positive, 7'b0};
            b[14] = b[14] & ALT_FLAG_MASK;
         end
      end

      // Additive checksum over the first fifteen bytes; the last slot is still zero here.
      for (int i = 0; i < 8; i++) begin
         lvl1[i] = b[2*i] + b[2*i+1];
      end
      for (int i = 0; i < 4; i++) begin
         lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
      end
      checksum = lvl3[0] + lvl3[1];

      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         frame[i] = b[i];
      end
      frame[FRAME_BYTES-1] = checksum;
   end

endmodule

/* design/rcq_serializer.sv */
`timescale 1ns / 1ps
`include "rc_quad_frame_builder_top_macros.svh"
module rcq_serializer
   import rcq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    s2_valid,
   output logic                    s2_ready,
   input  rcq_frame_type           frame,
   input  logic [7:0]              radio_channel,
   input  logic                    bind_frame,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              frame_byte,
   output logic [BYTE_INDEX_W-1:0] byte_index,
   output logic [7:0]              channel,
   output logic                    bind_flag,
   output logic                    last_byte
);

   logic                    busy_ff, busy_in;
   logic [BYTE_INDEX_W-1:0] idx_ff, idx_in;
   rcq_frame_type           frame_ff, frame_in;
   logic [7:0]              chan_ff, chan_in;
   logic                    bind_ff, bind_in;

   logic last;
   logic out_fire;
   logic load;

   assign last = (idx_ff == BYTE_INDEX_W'(FRAME_BYTES - 1));
   assign out_fire = busy_ff && rsp_tready;
   assign s2_ready = !busy_ff || (out_fire && last);
   assign load = s2_valid && s2_ready;

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      frame_in = frame_ff;
      chan_in = chan_ff;
      bind_in = bind_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in = '0;
         frame_in = frame;
         chan_in = radio_channel;
         bind_in = bind_frame;
      end else if (out_fire) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      chan_ff <= chan_in;
      bind_ff <= bind_in;
   end

   assign rsp_tvalid = busy_ff;
   assign frame_byte = frame_ff[idx_ff];
   assign byte_index = idx_ff;
   assign channel = chan_ff;
   assign bind_flag = bind_ff;
   assign last_byte = last;

   // Every byte but the last is followed by the next one of the same frame.
   `RCQ_ASSERT_NXT(a_idx_step, out_fire && !last, busy_ff && (idx_ff == $past(idx_ff) + 1'b1), "byte index did not step after a transfer")
   // Channel and bind tag hold for the whole frame.
   `RCQ_ASSERT_NXT(a_frame_hold, busy_ff && !(out_fire && last), $stable(chan_ff) && $stable(bind_ff), "frame tags changed inside a frame")
   // With no frame waiting, the final transfer leaves the output idle.
   `RCQ_ASSERT_NXT(a_drain, out_fire && last && !s2_valid, !busy_ff, "output stayed busy after the final byte")

endmodule
